// ----- rtl/core/gsrl_pkg.sv -----
// ----------------------------------------------------------------------------
// Gas sensor reading linearizer package
// Constants, codes and elaboration-time tables for the linearizer core.
// ----------------------------------------------------------------------------
`default_nettype none

package gsrl_pkg;

  // Field widths
  localparam int unsigned HeaterW = 16;
  localparam int unsigned SensorW = 24;
  localparam int unsigned TempW   = 19;
  localparam int unsigned ConcW   = 32;
  localparam int unsigned StatW   = 2;
  localparam int unsigned InDataW  = 40;  // heater + sensor, whole bytes
  localparam int unsigned OutDataW = 56;  // temperature + concentration, padded

  // Bridge arithmetic
  localparam int unsigned AW      = 50;   // 62500000 * x
  localparam int unsigned MantW   = 31;   // log2 mantissa, msb at bit 30
  localparam int unsigned FracW   = 24;   // fraction bits of log2 / exp2
  localparam int unsigned ExpW    = 6;    // integer part of log2
  localparam int unsigned LogW    = ExpW + FracW;

  localparam logic [25:0]   XCoef    = 26'd62500000;
  localparam logic [AW-1:0] OpenLim  = AW'(64'd56799211 * 64'd16777215);
  localparam logic [AW-1:0] InvalLim = AW'(64'd5511085 * 64'd16777215);
  localparam logic [29:0]   BMagQ30  = 30'd910419723;
  localparam logic signed [31:0] YOffset = 32'sd176962973;

  // Temperature: floor(tv / 234) as tv * ceil(2^34 / 234) >> 34, exact for tv < 2^26
  localparam int unsigned TvW       = 26;
  localparam logic [26:0] TempRecip = 27'd73418245;
  localparam int unsigned TempShift = 34;
  localparam int unsigned TempProdW = 53;

  typedef enum logic [StatW-1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_OPEN    = 2'd2
  } status_e;

  typedef logic [FracW:1][31:0] root_tab_t;

  function automatic longint unsigned isqrt_f(longint unsigned v);
    longint unsigned r;
    longint unsigned bt;
    longint unsigned rem;
    r   = 0;
    rem = v;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt != 0) begin
        if (rem >= r + bt) begin
          rem = rem - (r + bt);
          r   = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
    end
    return r;
  endfunction

  // r0 = 2^31, r_k = floor(sqrt(r_(k-1) * 2^30)): 2^(2^-k) in Q30
  function automatic root_tab_t root_tab_f();
    root_tab_t       tab;
    longint unsigned r;
    r = 64'd1 << 31;
    for (int k = 1; k <= FracW; k++) begin
      r      = isqrt_f(r << 30);
      tab[k] = 32'(r);
    end
    return tab;
  endfunction

  localparam root_tab_t RootTab = root_tab_f();

endpackage

`default_nettype wire

// ----- rtl/core/gas_sensor_reading_linearizer_core.sv -----
// ----------------------------------------------------------------------------
// Gas sensor reading linearizer core
// Converts one raw heater/sensor reading into temperature and concentration.
// ----------------------------------------------------------------------------
// Channel | Dir | Bus             | Contents (lowest bit up)
// s_axis  | in  | tdata[39:0]     | heater_code[15:0], sensor_code[39:16]
// m_axis  | out | tdata[55:0]     | heater_temp[18:0], concentration[50:19]
// m_axis  | out | tuser[1:0]      | status
//
// One reading is taken per cycle while no result waits at the output register.
// The depth is set by the two 24-step log2 squaring chains and the 24-step exp2
// root multiply chain, one 31x31 square or 31x32 multiply per step.
// The whole pipeline holds while a result waits at the output register.
// Reset clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gas_sensor_reading_linearizer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // heater_code [15:0], sensor_code [39:16]
  input  wire logic [gsrl_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // heater_temp [18:0], concentration [50:19], zero pad [55:51]
  output logic [gsrl_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // status [1:0]
  output logic [gsrl_pkg::StatW-1:0]         m_axis_tuser_o
);
  import gsrl_pkg::*;

  // Pipeline positions
  localparam int unsigned PIn   = 0;              // tv, a
  localparam int unsigned PCls  = 1;              // classify, E, D, temp product
  localparam int unsigned PNorm = 2;              // normalized mantissas
  localparam int unsigned PLogE = PNorm + FracW;  // last squaring step
  localparam int unsigned PDiff = PLogE + 1;      // |log2 E - log2 D|
  localparam int unsigned PMul  = PDiff + 1;      // times |B|
  localparam int unsigned PY    = PMul + 1;       // exponent y
  localparam int unsigned PSplt = PY + 1;         // integer / fraction split
  localparam int unsigned PExpE = PSplt + FracW;  // last root multiply
  localparam int unsigned Last  = PExpE + 1;      // output register
  localparam int unsigned NStg  = Last + 1;

  logic adv;
  logic [NStg-1:0] vld_q, vld_d;

  // Advance everything whenever the output slot is free or being drained
  assign adv             = !vld_q[Last] || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_comb begin
    vld_d = {vld_q[NStg-2:0], s_axis_tvalid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------- input
  logic [TvW-1:0] tv_q;
  logic [AW-1:0]  a_q;
  logic [HeaterW-1:0] heater_code;
  logic [SensorW-1:0] sensor_code;

  assign heater_code = s_axis_tdata_i[HeaterW-1:0];
  assign sensor_code = s_axis_tdata_i[HeaterW+SensorW-1:HeaterW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tv_q <= TvW'(32'(heater_code) * 32'd800 + 32'd63877);
      a_q  <= AW'(XCoef) * AW'(sensor_code);
    end
  end

  // ------------------------------------------------------------- classify
  status_e              stat_q [PCls:Last];
  logic signed [TempW-1:0] temp_q [PNorm:Last];
  logic [AW-1:0]        e_val_q, d_val_q;
  logic [TempProdW-1:0] tprod_q;
  status_e              stat_cls;

  always_comb begin
    if (a_q >= OpenLim) begin
      stat_cls = ST_OPEN;
    end else if (a_q <= InvalLim) begin
      stat_cls = ST_INVALID;
    end else begin
      stat_cls = ST_VALID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stat_q[PCls] <= stat_cls;
      e_val_q      <= a_q - InvalLim;
      d_val_q      <= OpenLim - a_q;
      tprod_q      <= TempProdW'(tv_q) * TempProdW'(TempRecip);
    end
  end

  // ------------------------------------------------------------ normalize
  logic [ExpW-1:0]  pe_c, pd_c;
  logic [AW-1:0]    se_c, sd_c;
  logic [MantW-1:0] me_q [PNorm:PLogE];
  logic [MantW-1:0] md_q [PNorm:PLogE];
  logic [ExpW-1:0]  pe_q [PNorm:PLogE];
  logic [ExpW-1:0]  pd_q [PNorm:PLogE];
  logic [FracW-1:0] fe_q [PNorm:PLogE];
  logic [FracW-1:0] fd_q [PNorm:PLogE];

  always_comb begin
    pe_c = '0;
    pd_c = '0;
    for (int i = 0; i < AW; i++) begin
      if (e_val_q[i]) pe_c = ExpW'(i);
      if (d_val_q[i]) pd_c = ExpW'(i);
    end
    // Put the leading one at the top, keep it and the 30 bits below it
    se_c = e_val_q << (ExpW'(AW - 1) - pe_c);
    sd_c = d_val_q << (ExpW'(AW - 1) - pd_c);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      me_q[PNorm]   <= se_c[AW-1:AW-MantW];
      md_q[PNorm]   <= sd_c[AW-1:AW-MantW];
      pe_q[PNorm]   <= pe_c;
      pd_q[PNorm]   <= pd_c;
      fe_q[PNorm]   <= '0;
      fd_q[PNorm]   <= '0;
      temp_q[PNorm] <= $signed(tprod_q[TempProdW-1:TempShift]) - 19'sd5000;
      stat_q[PNorm] <= stat_q[PCls];
    end
  end

  // ---------------------------------------------- log2 fraction, squaring
  for (genvar k = 1; k <= FracW; k++) begin : g_log
    localparam int unsigned P = PNorm + k;
    logic [2*MantW-1:0] sqe, sqd;
    logic [MantW:0]     he, hd;

    always_comb begin
      sqe = (2*MantW)'(me_q[P-1]) * (2*MantW)'(me_q[P-1]);
      sqd = (2*MantW)'(md_q[P-1]) * (2*MantW)'(md_q[P-1]);
      he  = sqe[2*MantW-1:MantW-1];
      hd  = sqd[2*MantW-1:MantW-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        // Square; a result at or above 2.0 yields a one bit and is halved
        me_q[P]   <= he[MantW] ? he[MantW:1] : he[MantW-1:0];
        md_q[P]   <= hd[MantW] ? hd[MantW:1] : hd[MantW-1:0];
        fe_q[P]   <= {fe_q[P-1][FracW-2:0], he[MantW]};
        fd_q[P]   <= {fd_q[P-1][FracW-2:0], hd[MantW]};
        pe_q[P]   <= pe_q[P-1];
        pd_q[P]   <= pd_q[P-1];
        temp_q[P] <= temp_q[P-1];
        stat_q[P] <= stat_q[P-1];
      end
    end
  end

  // ------------------------------------------------ scale by exponent B
  logic signed [LogW:0] tdiff_c;
  logic [LogW-1:0]      tabs_q;
  logic                 neg_q [PDiff:PY-1];
  logic [2*LogW-1:0]    prod_q;
  logic [2*LogW:0]      prnd_c;
  logic [LogW-1:0]      mag_c;
  logic signed [31:0]   y_q;

  always_comb begin
    tdiff_c = $signed({1'b0, pe_q[PLogE], fe_q[PLogE]})
            - $signed({1'b0, pd_q[PLogE], fd_q[PLogE]});
    prnd_c  = (2*LogW+1)'(prod_q) + ((2*LogW+1)'(1) << 29);
    mag_c   = prnd_c[2*LogW-1:30];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_q[PDiff]  <= tdiff_c[LogW];
      tabs_q        <= tdiff_c[LogW] ? LogW'(-tdiff_c) : LogW'(tdiff_c);
      temp_q[PDiff] <= temp_q[PLogE];
      stat_q[PDiff] <= stat_q[PLogE];

      neg_q[PMul]   <= neg_q[PDiff];
      prod_q        <= (2*LogW)'(tabs_q) * (2*LogW)'(BMagQ30);
      temp_q[PMul]  <= temp_q[PDiff];
      stat_q[PMul]  <= stat_q[PDiff];

      // Round half away from zero on the magnitude, then apply the sign
      y_q           <= neg_q[PMul] ? YOffset + $signed({2'b0, mag_c})
                                   : YOffset - $signed({2'b0, mag_c});
      temp_q[PY]    <= temp_q[PMul];
      stat_q[PY]    <= stat_q[PMul];
    end
  end

  // --------------------------------------------------- exp2 root chain
  logic [31:0]      yu_c;
  logic [MantW-1:0] acc_q [PSplt:PExpE];
  logic [FracW-1:0] f_q   [PSplt:PExpE];
  logic [ExpW-1:0]  n1_q  [PSplt:PExpE];
  logic             sat_q [PSplt:PExpE];
  logic             zro_q [PSplt:PExpE];

  assign yu_c = 32'(y_q + 32'sd16777216);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sat_q[PSplt]  <= y_q >= 32'sd536870912;
      zro_q[PSplt]  <= y_q < -32'sd16777216;
      n1_q[PSplt]   <= yu_c[FracW+ExpW-1:FracW];
      f_q[PSplt]    <= yu_c[FracW-1:0];
      acc_q[PSplt]  <= MantW'(1) << 30;
      temp_q[PSplt] <= temp_q[PY];
      stat_q[PSplt] <= stat_q[PY];
    end
  end

  for (genvar k = 1; k <= FracW; k++) begin : g_exp
    localparam int unsigned P = PSplt + k;
    logic [63:0] mp;

    assign mp = 64'(acc_q[P-1]) * 64'(RootTab[k]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        // Multiply in 2^(2^-k) where that fraction bit is set
        acc_q[P]  <= f_q[P-1][FracW-k] ? mp[30+MantW-1:30] : acc_q[P-1];
        f_q[P]    <= f_q[P-1];
        n1_q[P]   <= n1_q[P-1];
        sat_q[P]  <= sat_q[P-1];
        zro_q[P]  <= zro_q[P-1];
        temp_q[P] <= temp_q[P-1];
        stat_q[P] <= stat_q[P-1];
      end
    end
  end

  // ------------------------------------------------ round and saturate
  logic [ExpW-1:0]  rsh_c;
  logic [ConcW:0]   rsum_c;
  logic [ConcW+1:0] rhalf_c;
  logic [ConcW:0]   rval_c;
  logic [ConcW-1:0] conc_c;
  logic [ConcW-1:0] conc_q;

  always_comb begin
    // Value is 2*acc / 2^(32 - (n+1)), rounded half up
    rsh_c   = ExpW'(32) - n1_q[PExpE];
    rhalf_c = ((ConcW+2)'(1) << rsh_c) >> 1;
    rsum_c  = {acc_q[PExpE], 1'b0, 1'b0} >> 1;
    rsum_c  = rsum_c + rhalf_c[ConcW:0];
    rval_c  = rsum_c >> rsh_c;
    if (stat_q[PExpE] != ST_VALID || zro_q[PExpE]) begin
      conc_c = '0;
    end else if (sat_q[PExpE] || rval_c[ConcW]) begin
      conc_c = '1;
    end else begin
      conc_c = rval_c[ConcW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      conc_q       <= conc_c;
      temp_q[Last] <= temp_q[PExpE];
      stat_q[Last] <= stat_q[PExpE];
    end
  end

  assign m_axis_tvalid_o = vld_q[Last];
  assign m_axis_tdata_o  = {(OutDataW-TempW-ConcW)'(0), conc_q, temp_q[Last]};
  assign m_axis_tuser_o  = stat_q[Last];

  // ------------------------------------------------------------ checks
  // Any status other than valid carries a zero concentration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_VALID |-> m_axis_tdata_o[50:19] == '0)
    else $error("nonzero concentration with a failing status");

  // An accepted transaction lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[PIn])
    else $error("accepted transaction lost at pipeline entry");

  // A stall freezes every stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ----- tb/sv/gsrl_reading_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gas sensor reading linearizer checker
// Watches both stream channels, converts each accepted reading on its own and
// compares every returned result, field by field, in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module gsrl_reading_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  input  wire logic                          s_axis_tready_i,
  input  wire logic [gsrl_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  wire logic                          m_axis_tvalid_i,
  input  wire logic                          m_axis_tready_i,
  input  wire logic [gsrl_pkg::OutDataW-1:0] m_axis_tdata_i,
  input  wire logic [gsrl_pkg::StatW-1:0]    m_axis_tuser_i,
  output int                                 mismatch_cnt_o,
  output int                                 readings_in_flight_o
);
  import gsrl_pkg::*;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [ConcW-1:0]        conc;
    status_e                 status;
  } reading_t;

  localparam longint unsigned FullScale = 64'd16777215;
  localparam longint unsigned OpenBound = 64'd56799211 * FullScale;
  localparam longint unsigned InvalBound = 64'd5511085 * FullScale;
  localparam longint unsigned Q30 = 64'd1 << 30;

  reading_t        expected_readings[$];
  longint unsigned exp_roots[1:24];

  // Digit-by-digit square root
  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, probe;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      probe = res | (64'd1 << b);
      if (probe <= 64'd4294967295 && probe * probe <= v) res = probe;
    end
    return res;
  endfunction

  // log2 in Q24: integer part from the leading one, fraction by squaring
  function automatic longint unsigned log2_q24(longint unsigned v);
    int              lead;
    longint unsigned mant, frac;
    lead = 0;
    for (int i = 0; i < 64; i++) if (v[i]) lead = i;
    mant = (lead >= 30) ? (v >> (lead - 30)) : (v << (30 - lead));
    frac = 0;
    for (int i = 0; i < 24; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(lead) << 24) | frac;
  endfunction

  function automatic logic [31:0] exp2_sat(longint y);
    longint unsigned yu, fr, acc, val;
    longint          whole;
    int              sh;
    if (y >= (longint'(32) << 24)) return 32'hFFFF_FFFF;
    if (y < -(longint'(1) << 24)) return 32'd0;
    yu    = longint'(y + (longint'(1) << 24));
    whole = longint'(yu >> 24) - 1;
    fr    = yu & 64'hFF_FFFF;
    acc   = Q30;
    for (int k = 1; k <= 24; k++) if (fr[24-k]) acc = (acc * exp_roots[k]) >> 30;
    sh = 30 - int'(whole);
    if (sh > 0) val = (acc + (64'd1 << (sh - 1))) >> sh;
    else val = acc << (-sh);
    if (val > 64'hFFFF_FFFF) val = 64'hFFFF_FFFF;
    return val[31:0];
  endfunction

  function automatic reading_t linearize_reading(logic [HeaterW-1:0] heater,
                                                 logic [SensorW-1:0] sensor);
    reading_t        r;
    longint unsigned tv, amp, mag;
    longint          t, sub, tq;
    tv     = 64'd800 * heater + 64'd63877;
    tq     = longint'(tv / 64'd234) - 5000;
    r.temp = tq[TempW-1:0];
    r.conc = '0;
    amp    = 64'd62500000 * sensor;
    if (amp >= OpenBound) begin
      r.status = ST_OPEN;
    end else if (amp <= InvalBound) begin
      r.status = ST_INVALID;
    end else begin
      t = longint'(log2_q24(amp - InvalBound)) - longint'(log2_q24(OpenBound - amp));
      // round the scaled log difference, ties away from zero
      mag = (64'd910419723 * longint'(t < 0 ? -t : t) + (Q30 >> 1)) >> 30;
      sub = (t < 0) ? -longint'(mag) : longint'(mag);
      r.conc   = exp2_sat(longint'(176962973) - sub);
      r.status = ST_VALID;
    end
    return r;
  endfunction

  initial begin
    longint unsigned rt;
    rt = 64'd1 << 31;
    for (int k = 1; k <= 24; k++) begin
      rt = sqrt_floor(rt << 30);
      exp_roots[k] = rt;
    end
  end

  assign readings_in_flight_o = expected_readings.size();

  always @(posedge clk_i) begin
    reading_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_readings.push_back(linearize_reading(s_axis_tdata_i[15:0],
                                                      s_axis_tdata_i[39:16]));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.temp   = m_axis_tdata_i[18:0];
        got.conc   = m_axis_tdata_i[50:19];
        got.status = status_e'(m_axis_tuser_i);
        if (expected_readings.size() == 0) begin
          $display("%0t: result with nothing expected: temp %0d conc %0d status %0d",
                   $realtime, got.temp, got.conc, got.status);
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end else begin
          want = expected_readings.pop_front();
          if (got.temp !== want.temp)
            $display("%0t: heater_temp expected %0d actual %0d",
                     $realtime, want.temp, got.temp);
          if (got.conc !== want.conc)
            $display("%0t: concentration expected %0d actual %0d",
                     $realtime, want.conc, got.conc);
          if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d",
                     $realtime, want.status, got.status);
          if (got !== want) mismatch_cnt_o <= mismatch_cnt_o + 1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gas sensor reading linearizer testbench
// Drives directed and random readings with random gaps and output stalls,
// including a long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import gsrl_pkg::*;

  localparam int unsigned RandomReadings = 730;
  localparam int unsigned StallLimit     = 5000;
  // sensor codes at the edges of the bridge's valid range
  localparam logic [23:0] InvalEdge = 24'((64'd5511085 * 64'd16777215) / 64'd62500000);
  localparam logic [23:0] OpenEdge  =
    24'((64'd56799211 * 64'd16777215 + 64'd62499999) / 64'd62500000);

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [StatW-1:0]    m_axis_tuser_o;
  int                  mismatch_cnt;
  int                  readings_in_flight;
  int                  idle_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  gas_sensor_reading_linearizer_core DUT (.*);

  gsrl_reading_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o),
    .mismatch_cnt_o(mismatch_cnt), .readings_in_flight_o(readings_in_flight)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one reading and hold it until the transaction completes
  task automatic send_reading(logic [15:0] heater, logic [23:0] sensor);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {sensor, heater};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Sensor codes: mostly inside the bridge range, some at its edges, some anywhere
  function automatic logic [23:0] pick_sensor();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 24'($urandom_range(OpenEdge - 1, InvalEdge + 1));
    if (roll < 75) return InvalEdge + 24'($urandom_range(3000)) - 24'd10;
    if (roll < 85) return OpenEdge - 24'($urandom_range(3000)) + 24'd10;
    return 24'($urandom);
  endfunction

  // Receiver: random stalls, one long hold-off that fills the pipeline
  initial begin
    int cyc;
    int hold;
    cyc  = 0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 1500) hold = 400;
      if (hold > 0) begin
        hold--;
        m_axis_tready_i <= 1'b0;
      end else if ((cyc / 300) % 4 == 3) begin
        m_axis_tready_i <= 1'b1;  // stretch with no stalls
      end else if ($urandom_range(99) < 10) begin
        m_axis_tready_i <= 1'b0;
        hold = $urandom_range(99) < 85 ? $urandom_range(3) : $urandom_range(30, 8);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("gas_sensor_reading_linearizer_core verification failed");
      $finish;
    end
  end

  initial begin
    logic [23:0] edges[$];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, open and invalid limits, both saturations
    edges = '{24'd0, 24'hFFFFFF, InvalEdge, InvalEdge + 24'd1, InvalEdge + 24'd2,
              InvalEdge + 24'd40, OpenEdge - 24'd1, OpenEdge, OpenEdge - 24'd2,
              OpenEdge - 24'd200, 24'h555555, 24'hAAAAAA, 24'h800000, 24'h400000};
    foreach (edges[i]) send_reading(i[0] ? 16'hFFFF : 16'h0000, edges[i]);
    send_reading(16'h5555, 24'hAAAAAA);
    send_reading(16'hAAAA, 24'h555555);
    send_reading(16'h8000, OpenEdge + 24'd1);

    for (int n = 0; n < RandomReadings; n++) begin
      // pause once until every result has drained
      if (n == 500) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        while (readings_in_flight != 0) @(posedge clk_i);
      end
      send_reading(16'($urandom), pick_sensor());
    end
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);

    while (readings_in_flight != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("gas_sensor_reading_linearizer_core verification clean");
    end else begin
      $display("gas_sensor_reading_linearizer_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/gsrl_pkg.sv
rtl/core/gas_sensor_reading_linearizer_core.sv
tb/sv/gsrl_reading_checker.sv
tb/sv/tb.sv
